// File: rtl/fitch_insertion_cost_bounded_core_macros.svh
// Assertion macros for the Fitch insertion cost core.
// Used by fitch_insertion_cost_bounded_core.sv; expects aclk and aresetn in scope.
`ifndef FITCH_INSERTION_COST_BOUNDED_CORE_MACROS_SVH
`define FITCH_INSERTION_COST_BOUNDED_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define FICB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FICB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FICB_ASSERT_NOW(label, ante, cons)
`define FICB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/ficb_pkg.sv
// Shared types and constants for the Fitch insertion cost core.
// No dependencies; imported by fitch_insertion_cost_bounded_core.
`default_nettype none

package ficb_pkg;

    localparam int MAX_SITES   = 4096;
    localparam int SITE_W      = 13;
    localparam int INDEX_LIMIT = (MAX_SITES < 8191) ? MAX_SITES : 8191;
    localparam int STATE_W     = 5;
    localparam int COST_W      = 16;
    localparam int WEIGHT_W    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPLIT_MODE         = 4'd0,
        REG_SUBST_COST         = 4'd1,
        REG_TRANSITION_COST    = 4'd2,
        REG_TRANSVERSION_COST  = 4'd3,
        REG_INDEL_COST         = 4'd4,
        REG_BASE_SITES         = 4'd5,
        REG_TRANSVERSION_SITES = 4'd6,
        REG_MISSING_THRESHOLD  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [STATE_W-1:0] taxon_state;
        logic [STATE_W-1:0] first_end_state;
        logic [STATE_W-1:0] second_end_state;
        logic [COST_W-1:0]  cost_bound;
        logic               last_site;
    } site_in_t;

    typedef struct packed {
        logic [COST_W-1:0] total_cost;
        logic              over_bound;
    } site_out_t;

endpackage

`default_nettype wire

// File: rtl/fitch_insertion_cost_bounded_core.sv
// Top level of the bounded Fitch insertion cost core.
// Depends on ficb_pkg.sv and fitch_insertion_cost_bounded_core_macros.svh.
//
// Usage:
//   s_ channel: one transaction per aligned site (taxon and branch end state sets,
//   the current cost bound, a last-site mark). One site per cycle unless stalled.
//   m_ channel: one transaction per insertion, issued for the site marked last,
//   carrying the saturated total cost and the over-bound flag.
//   cfg channel: register writes by index; always ready. Writes are expected only
//   while no insertion is in flight. Unknown indexes are ignored.
// Pipeline: a last site passes two register stages, site pricing and then
//   accumulation, before its result shows on m_.
// Throughput: one site per cycle unless a last site stalls; the limit is the add,
//   saturate and bound compare on the running cost.
// Reset: aresetn low (synchronous) loads the register defaults, clears the site
//   counter, running cost and flag, and empties both pipeline stages.
// Stall: a held result holds the next last site in the pricing stage, blocking s_;
//   sites ahead of it keep flowing into the accumulator while the receiver stalls.
`default_nettype none
`include "fitch_insertion_cost_bounded_core_macros.svh"

module fitch_insertion_cost_bounded_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire ficb_pkg::site_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output ficb_pkg::site_out_t                  m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ficb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ficb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ficb_pkg::*;

    // Configuration registers.
    logic                split_mode_reg;
    logic [WEIGHT_W-1:0] subst_cost_reg;
    logic [WEIGHT_W-1:0] transition_cost_reg;
    logic [WEIGHT_W-1:0] transversion_cost_reg;
    logic [WEIGHT_W-1:0] indel_cost_reg;
    logic [SITE_W-1:0]   base_sites_reg;
    logic [SITE_W-1:0]   transversion_sites_reg;
    logic [STATE_W-1:0]  missing_threshold_reg;

    // Site pricing stage.
    logic                s1_valid_reg;
    logic [WEIGHT_W-1:0] s1_cost_reg;
    logic [COST_W-1:0]   s1_bound_reg;
    logic                s1_last_reg;
    logic [SITE_W-1:0]   site_index_reg;

    // Accumulation state and result register.
    logic [COST_W-1:0]   running_cost_reg;
    logic                bound_reached_reg;
    logic                out_valid_reg;
    site_out_t           out_data_reg;

    logic                s_accept;
    logic                s1_advance;
    logic                out_free;
    logic [STATE_W-1:0]  branch_union;
    logic [STATE_W-1:0]  branch_set;
    logic                mismatch;
    logic [SITE_W-1:0]   transition_end;
    logic [WEIGHT_W-1:0] class_cost;
    logic [WEIGHT_W-1:0] s1_cost_next;
    logic [SITE_W-1:0]   site_index_next;
    logic [COST_W:0]     cost_sum;
    logic [COST_W-1:0]   cost_sat;
    logic                flag_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_mode_reg         <= 1'b0;
            subst_cost_reg         <= WEIGHT_W'(1);
            transition_cost_reg    <= WEIGHT_W'(1);
            transversion_cost_reg  <= WEIGHT_W'(1);
            indel_cost_reg         <= WEIGHT_W'(1);
            base_sites_reg         <= '0;
            transversion_sites_reg <= '0;
            missing_threshold_reg  <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SPLIT_MODE:         split_mode_reg         <= cfg_data[0];
                REG_SUBST_COST:         subst_cost_reg         <= cfg_data[WEIGHT_W-1:0];
                REG_TRANSITION_COST:    transition_cost_reg    <= cfg_data[WEIGHT_W-1:0];
                REG_TRANSVERSION_COST:  transversion_cost_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_INDEL_COST:         indel_cost_reg         <= cfg_data[WEIGHT_W-1:0];
                REG_BASE_SITES:         base_sites_reg         <= cfg_data[SITE_W-1:0];
                REG_TRANSVERSION_SITES: transversion_sites_reg <= cfg_data[SITE_W-1:0];
                REG_MISSING_THRESHOLD:  missing_threshold_reg  <= cfg_data[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the pricing stage drains whenever its site is not last or
    // the result register can take a new transaction.
    assign out_free   = !out_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // Site pricing from the incoming sets and the current site index.
    always_comb begin
        branch_union = s_data.first_end_state | s_data.second_end_state;
        if (branch_union > missing_threshold_reg) begin
            branch_set = s_data.first_end_state & s_data.second_end_state;
        end else begin
            branch_set = branch_union;
        end
        mismatch = (s_data.taxon_state & branch_set) == '0;

        // When the transversion count exceeds the base count, all base sites
        // are transversions.
        if (transversion_sites_reg <= base_sites_reg) begin
            transition_end = base_sites_reg - transversion_sites_reg;
        end else begin
            transition_end = '0;
        end

        priority if (site_index_reg >= base_sites_reg) begin
            class_cost = indel_cost_reg;
        end else if (!split_mode_reg) begin
            class_cost = subst_cost_reg;
        end else if (site_index_reg < transition_end) begin
            class_cost = transition_cost_reg;
        end else begin
            class_cost = transversion_cost_reg;
        end

        s1_cost_next = mismatch ? class_cost : '0;

        if (s_data.last_site) begin
            site_index_next = '0;
        end else if (site_index_reg < SITE_W'(INDEX_LIMIT)) begin
            site_index_next = site_index_reg + SITE_W'(1);
        end else begin
            site_index_next = site_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            site_index_reg <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg   <= 1'b1;
                site_index_reg <= site_index_next;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cost_reg  <= s1_cost_next;
            s1_bound_reg <= s_data.cost_bound;
            s1_last_reg  <= s_data.last_site;
        end
    end

    // Accumulation: saturating add, then the sticky bound compare.
    always_comb begin
        cost_sum  = {1'b0, running_cost_reg} + (COST_W+1)'(s1_cost_reg);
        cost_sat  = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        flag_next = bound_reached_reg || (cost_sat >= s1_bound_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_cost_reg  <= '0;
            bound_reached_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (s1_advance) begin
                if (s1_last_reg) begin
                    running_cost_reg  <= '0;
                    bound_reached_reg <= 1'b0;
                end else begin
                    running_cost_reg  <= cost_sat;
                    bound_reached_reg <= flag_next;
                end
            end
            if (s1_advance && s1_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_last_reg) begin
            out_data_reg.total_cost <= cost_sat;
            out_data_reg.over_bound <= flag_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `FICB_ASSERT_NEXT(a_last_gives_result, s1_advance && s1_last_reg, out_valid_reg)
    `FICB_ASSERT_NEXT(a_last_clears_state, s1_advance && s1_last_reg,
        running_cost_reg == '0 && !bound_reached_reg)
    `FICB_ASSERT_NEXT(a_cost_monotonic, s1_advance && !s1_last_reg,
        running_cost_reg >= $past(running_cost_reg))
    `FICB_ASSERT_NOW(a_index_limit, 1'b1, site_index_reg <= SITE_W'(INDEX_LIMIT))

endmodule

`default_nettype wire
